// ===== hdl/directional_movement_index_assert.svh =====
// Assertion macros for the directional movement index port checker.
`ifndef DIRECTIONAL_MOVEMENT_INDEX_ASSERT_SVH
`define DIRECTIONAL_MOVEMENT_INDEX_ASSERT_SVH

// Check a consequent in the same cycle as its trigger.
`define DMI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its trigger.
`define DMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dmi_pkg.sv =====
// Shared constants and types for the directional movement index.
package dmi_pkg;

  localparam int DEF_WINDOW     = 10;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_PRICE_BITS = 24;

  // Fixed field widths of the bar and result beats
  localparam int IN_PRICE_W  = 24;
  localparam int OUT_FIXED_W = 23;

  // DX scale factor and the integer bits its quotient needs (100 < 2**7)
  localparam int DX_SCALE = 100;
  localparam int DX_INT_W = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOVE,
    ST_DIFF,
    ST_DXLOAD,
    ST_DXDIV,
    ST_DXSUM,
    ST_ADXLOAD,
    ST_FINISH
  } dmi_state_t;

endpackage

// ===== hdl/dmi_if.sv =====
// Valid/ready channel interfaces for price bars and index results.
interface dmi_bar_if;
  import dmi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IN_PRICE_W-1:0] bar_high;
  logic [IN_PRICE_W-1:0] bar_low;
  logic [IN_PRICE_W-1:0] bar_close;

  modport source (output valid, output bar_high, output bar_low, output bar_close,
                  input ready);
  modport sink   (input valid, input bar_high, input bar_low, input bar_close,
                  output ready);
endinterface

interface dmi_res_if;
  import dmi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OUT_FIXED_W-1:0] adx_value;
  logic [OUT_FIXED_W-1:0] dx_value;
  logic                   trend_rising;
  logic                   adx_valid;

  modport source (output valid, output adx_value, output dx_value,
                  output trend_rising, output adx_valid, input ready);
  modport sink   (input valid, input adx_value, input dx_value,
                  input trend_rising, input adx_valid, output ready);
endinterface

// ===== hdl/directional_movement_index.sv =====
// Directional movement index (ADX over simple moving sums), one result per price bar.
//
//   channel   | dir | handshake               | beat contents
//   ----------+-----+-------------------------+--------------------------------------
//   in_bar    | in  | valid/ready             | bar_high, bar_low, bar_close
//   out_res   | out | valid/ready             | adx_value, dx_value, trend_rising,
//             |     |                         | adx_valid
//
// Steps: a bar accepted in ST_IDLE passes ST_MOVE, ST_DIFF, ST_DXLOAD, ST_DXDIV,
//   ST_DXSUM, ST_ADXLOAD and ST_FINISH; a bar whose DX is forced to zero (warm-up,
//   or P+M zero) skips ST_DXDIV. The restoring divider gives one quotient bit per
//   cycle for DX; the ADX mean is a reciprocal multiply registered in ST_ADXLOAD.
//   No new bar is taken until the current one has left ST_FINISH.
// Reset: rst_n is synchronous, active low; it clears sums, counters, the FSM and the
//   per-entry valid bits of the delay-line memory, so no clearing pass is needed.
// Stalls: the result sits in an output register; a stalled out_res only holds the
//   block in its last step, and in_bar.ready rises again as soon as the beat is parked.
module directional_movement_index #(
  parameter int WINDOW     = dmi_pkg::DEF_WINDOW,
  parameter int FRAC_BITS  = dmi_pkg::DEF_FRAC_BITS,
  parameter int PRICE_BITS = dmi_pkg::DEF_PRICE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  dmi_bar_if.sink   in_bar,
  dmi_res_if.source out_res
);
  import dmi_pkg::*;

  // ---------------------------------------------------------------------------------
  // Derived widths
  // ---------------------------------------------------------------------------------
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW);     // running movement sums
  localparam int TOT_W  = SUM_W + 1;                       // P + M
  localparam int DX_W   = FRAC_BITS + DX_INT_W;            // DX, 0..100 in fixed point
  localparam int DXS_W  = DX_W + $clog2(WINDOW);           // sum of WINDOW DX values
  localparam int R_DX   = TOT_W + DX_INT_W;
  localparam int R_W    = R_DX;                            // divider remainder
  localparam int CNT_W  = $clog2(DX_W);
  localparam int ENT_W  = 2 * PRICE_BITS + DX_W;           // {pm, mm, dx} per entry
  localparam int BC_W   = $clog2(2 * WINDOW - 1);          // holds up to 2*WINDOW-2
  localparam int PIN_W  = (IN_PRICE_W > PRICE_BITS) ? IN_PRICE_W : PRICE_BITS;
  localparam int OXW    = (DX_W > OUT_FIXED_W) ? DX_W : OUT_FIXED_W;

  // ADX mean: floor(dx_sum / WINDOW) = (dx_sum * ceil(2**ADX_SH / WINDOW)) >> ADX_SH,
  // exact for every dx_sum below 2**DXS_W
  localparam int ADX_SH = DXS_W + $clog2(WINDOW);
  localparam int RCP_W  = DXS_W + 1;
  localparam int PROD_W = DXS_W + RCP_W;
  localparam logic [RCP_W-1:0] ADX_RCP =
    RCP_W'(((64'd1 << ADX_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [BC_W-1:0]  VALID_AT = BC_W'(2 * WINDOW - 2);
  localparam logic [BC_W-1:0]  DX_START = BC_W'(WINDOW - 1);
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW - 1);

  // ---------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------
  dmi_state_t state_r, state_nxt;

  logic [PRICE_BITS-1:0] prev_high_r, prev_low_r;
  logic [PRICE_BITS-1:0] pm_r, mm_r;
  logic [SUM_W-1:0]      psum_r, msum_r;
  logic [TOT_W-1:0]      tot_r;
  logic [SUM_W-1:0]      diff_r;
  logic                  dx_act_r;
  logic [DXS_W-1:0]      dx_sum_r, prev_dx_sum_r;
  logic [DX_W-1:0]       dx_r;
  logic [DX_W-1:0]       adx_r;
  logic [BC_W-1:0]       bar_count_r;
  logic [IDX_W-1:0]      pos_r;

  // Delay lines for plus movement, minus movement and DX share one memory
  logic [ENT_W-1:0]      line_mem [WINDOW];
  logic [ENT_W-1:0]      rd_q_r;
  logic [WINDOW-1:0]     line_vld_r;

  // Restoring divider for DX
  logic [R_W-1:0]        div_rem_r, div_den_r;
  logic [DX_W-1:0]       div_q_r;
  logic [CNT_W-1:0]      div_cnt_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_FIXED_W-1:0] out_adx_r, out_dx_r;
  logic                   out_rising_r, out_adx_valid_r;

  // ---------------------------------------------------------------------------------
  // FSM outputs
  // ---------------------------------------------------------------------------------
  logic in_acc, div_step, line_wr, out_load, div_last;

  always_comb begin
    in_bar.ready = 1'b0;
    div_step     = 1'b0;
    line_wr      = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_bar.ready = 1'b1;
      ST_DXDIV:   div_step     = 1'b1;
      ST_DXSUM:   line_wr      = 1'b1;
      ST_FINISH:  out_load     = !out_valid_r || out_res.ready;
      default: begin
      end
    endcase
  end

  assign in_acc   = in_bar.valid && in_bar.ready;
  assign div_last = (div_cnt_r == '0);

  logic valid_now;
  assign valid_now = (bar_count_r >= VALID_AT);

  // ---------------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_bar.valid) state_nxt = ST_MOVE;
      ST_MOVE:    state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_DXLOAD;
      ST_DXLOAD:  state_nxt = dx_act_r ? ST_DXDIV : ST_DXSUM;
      ST_DXDIV:   if (div_last) state_nxt = ST_DXSUM;
      ST_DXSUM:   state_nxt = ST_ADXLOAD;
      ST_ADXLOAD: state_nxt = ST_FINISH;
      ST_FINISH:  if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------------
  // Directional movement of the incoming bar
  // ---------------------------------------------------------------------------------
  logic [PIN_W-1:0]      hi_ext, lo_ext;
  logic [PRICE_BITS-1:0] hi, lo, pm_raw, mm_raw, pm_new, mm_new;

  assign hi_ext = PIN_W'(in_bar.bar_high);
  assign lo_ext = PIN_W'(in_bar.bar_low);
  assign hi     = hi_ext[PRICE_BITS-1:0];
  assign lo     = lo_ext[PRICE_BITS-1:0];
  assign pm_raw = (hi > prev_high_r) ? hi - prev_high_r : '0;
  assign mm_raw = (prev_low_r > lo) ? prev_low_r - lo : '0;

  always_comb begin
    pm_new = '0;
    mm_new = '0;
    // First bar has no predecessor; otherwise keep only the strictly larger move
    if (bar_count_r != '0) begin
      if (pm_raw > mm_raw) begin
        pm_new = pm_raw;
      end else if (mm_raw > pm_raw) begin
        mm_new = mm_raw;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Values leaving the window (an entry never written reads as zero)
  // ---------------------------------------------------------------------------------
  logic [ENT_W-1:0]      old_ent;
  logic [PRICE_BITS-1:0] old_pm, old_mm;
  logic [DX_W-1:0]       old_dx;

  assign old_ent = line_vld_r[pos_r] ? rd_q_r : '0;
  assign old_pm  = old_ent[ENT_W-1 -: PRICE_BITS];
  assign old_mm  = old_ent[DX_W +: PRICE_BITS];
  assign old_dx  = old_ent[DX_W-1:0];

  // ---------------------------------------------------------------------------------
  // Sums, difference and DX
  // ---------------------------------------------------------------------------------
  logic [TOT_W-1:0] tot_nxt;
  logic [SUM_W-1:0] diff_nxt;
  logic [DX_W-1:0]  dx_cur;
  logic [DXS_W-1:0] dx_sum_nxt;

  assign tot_nxt    = TOT_W'(psum_r) + TOT_W'(msum_r);
  assign diff_nxt   = (psum_r >= msum_r) ? psum_r - msum_r : msum_r - psum_r;
  assign dx_cur     = dx_act_r ? div_q_r : '0;
  assign dx_sum_nxt = dx_sum_r - DXS_W'(old_dx) + DXS_W'(dx_cur);

  // ---------------------------------------------------------------------------------
  // Divider step: compare against the shifted divisor, subtract, shift one bit left
  // ---------------------------------------------------------------------------------
  logic           div_ge;
  logic [R_W-1:0] div_sub, div_rem_step;

  assign div_ge       = (div_rem_r >= div_den_r);
  assign div_sub      = div_rem_r - div_den_r;
  assign div_rem_step = (div_ge ? div_sub : div_rem_r) << 1;

  // ADX mean by reciprocal multiplication of the updated DX sum
  logic [PROD_W-1:0] adx_prod;

  assign adx_prod = PROD_W'(dx_sum_r) * PROD_W'(ADX_RCP);

  // ---------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_high_r   <= '0;
      prev_low_r    <= '0;
      psum_r        <= '0;
      msum_r        <= '0;
      dx_sum_r      <= '0;
      prev_dx_sum_r <= '0;
      bar_count_r   <= '0;
      pos_r         <= '0;
      line_vld_r    <= '0;
      dx_act_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Latch movements and move the previous-bar reference forward
      if (in_acc) begin
        pm_r        <= pm_new;
        mm_r        <= mm_new;
        prev_high_r <= hi;
        prev_low_r  <= lo;
      end

      // Replace the oldest movement in each running sum
      if (state_r == ST_MOVE) begin
        psum_r <= psum_r - SUM_W'(old_pm) + SUM_W'(pm_r);
        msum_r <= msum_r - SUM_W'(old_mm) + SUM_W'(mm_r);
      end

      if (state_r == ST_DIFF) begin
        tot_r    <= tot_nxt;
        diff_r   <= diff_nxt;
        dx_act_r <= (bar_count_r >= DX_START) && (tot_nxt != '0);
      end

      // Retire the DX of this bar into the window and advance the line pointer
      if (line_wr) begin
        dx_r              <= dx_cur;
        dx_sum_r          <= dx_sum_nxt;
        line_vld_r[pos_r] <= 1'b1;
        pos_r             <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
      end

      // Close the bar: remember this ADX sum (zero in warm-up), count warm-up bars
      if (out_load) begin
        prev_dx_sum_r <= valid_now ? dx_sum_r : '0;
        if (!valid_now) begin
          bar_count_r <= bar_count_r + 1'b1;
        end
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_DXLOAD) begin
      // floor(100*diff*2**FRAC_BITS / total): divisor scaled to the top quotient bit
      div_rem_r <= R_W'(diff_r) * R_W'(DX_SCALE);
      div_den_r <= R_W'(tot_r) << (DX_INT_W - 1);
      div_cnt_r <= CNT_W'(DX_W - 1);
      div_q_r   <= '0;
    end else if (div_step) begin
      div_rem_r <= div_rem_step;
      div_q_r   <= {div_q_r[DX_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r - 1'b1;
    end
  end

  // Latch the ADX mean once the new DX sum is in place
  always_ff @(posedge clk) begin
    if (state_r == ST_ADXLOAD) begin
      adx_r <= adx_prod[ADX_SH +: DX_W];
    end
  end

  // Delay-line memory: read at accept, written back once DX is known
  always_ff @(posedge clk) begin
    if (line_wr) begin
      line_mem[pos_r] <= {pm_r, mm_r, dx_cur};
    end
    if (in_acc) begin
      rd_q_r <= line_mem[pos_r];
    end
  end

  // ---------------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------------
  logic [OXW-1:0] adx_ext, dx_ext;

  assign adx_ext = valid_now ? OXW'(adx_r) : '0;
  assign dx_ext  = OXW'(dx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_adx_r       <= adx_ext[OUT_FIXED_W-1:0];
      out_dx_r        <= dx_ext[OUT_FIXED_W-1:0];
      out_rising_r    <= valid_now && (dx_sum_r >= prev_dx_sum_r);
      out_adx_valid_r <= valid_now;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.adx_value    = out_adx_r;
  assign out_res.dx_value     = out_dx_r;
  assign out_res.trend_rising = out_rising_r;
  assign out_res.adx_valid    = out_adx_valid_r;

endmodule

// ===== hdl/dmi_checker.sv =====
// Port-level checker for the directional movement index, bound to the top level.
`include "directional_movement_index_assert.svh"

module dmi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dmi_pkg::OUT_FIXED_W-1:0] adx_value,
  input logic [dmi_pkg::OUT_FIXED_W-1:0] dx_value,
  input logic                            trend_rising,
  input logic                            adx_valid
);
  import dmi_pkg::*;

  // Hold a stalled result beat
  `DMI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(adx_value) && $stable(dx_value) && $stable(trend_rising) && $stable(adx_valid), "result beat changed while stalled")

  // Drop ready once a bar is taken
  `DMI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "bar accepted while busy")

  // Raise a result only after the block was busy with a bar
  `DMI_ASSERT_SAME(a_out_after_work, $rose(out_valid), !$past(in_ready), "result without work")

  // Hold ADX and trend at zero during warm-up
  `DMI_ASSERT_SAME(a_warmup_zero, out_valid && !adx_valid, adx_value == '0 && !trend_rising, "ADX fields set before valid window")

endmodule

bind directional_movement_index dmi_checker u_dmi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bar.valid),
  .in_ready     (in_bar.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .adx_value    (out_res.adx_value),
  .dx_value     (out_res.dx_value),
  .trend_rising (out_res.trend_rising),
  .adx_valid    (out_res.adx_valid)
);

// ===== bench/dmi_result_checker.sv =====
// Result checker for the directional movement index: predicts each bar's index and compares.
`timescale 1ns / 1ps

module dmi_result_checker
  import dmi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  dmi_bar_if   bar,
  dmi_res_if   res,
  output int   mismatches,
  output int   pending
);

  localparam int WIN      = DEF_WINDOW;
  localparam int VALID_AT = 2 * WIN - 2;
  localparam int SUM_W    = IN_PRICE_W + 4;
  localparam int DXSUM_W  = OUT_FIXED_W + 4;
  localparam int SHOWN    = 40;

  typedef logic [IN_PRICE_W-1:0]  price_t;
  typedef logic [OUT_FIXED_W-1:0] fixed_t;

  typedef struct packed {
    fixed_t adx;
    fixed_t dx;
    logic   rising;
    logic   valid;
  } index_beat_t;

  price_t               last_high;
  price_t               last_low;
  price_t               plus_hist  [WIN];
  price_t               minus_hist [WIN];
  fixed_t               dx_hist    [WIN];
  logic [SUM_W-1:0]     plus_total;
  logic [SUM_W-1:0]     minus_total;
  logic [DXSUM_W-1:0]   dx_total;
  logic [DXSUM_W-1:0]   last_adx_total;
  int                   bars_seen;
  int                   slot;
  index_beat_t          index_due [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= SHOWN) begin
      $display("%0t dmi check: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  // Advance the index state by one bar and return the beat it must produce.
  function automatic index_beat_t index_after_bar(input price_t hi, input price_t lo);
    price_t             up_move;
    price_t             down_move;
    logic [SUM_W-1:0]   spread;
    logic [SUM_W-1:0]   both;
    logic [63:0]        scaled;
    fixed_t             dx_now;
    logic [DXSUM_W-1:0] adx_total;
    index_beat_t        beat;
    up_move   = '0;
    down_move = '0;
    dx_now    = '0;
    adx_total = '0;
    beat      = '0;
    if (bars_seen > 0) begin
      up_move   = (hi > last_high) ? price_t'(hi - last_high) : '0;
      down_move = (last_low > lo) ? price_t'(last_low - lo) : '0;
      // keep only the larger move; a tie cancels both
      if (up_move > down_move) begin
        down_move = '0;
      end else if (down_move > up_move) begin
        up_move = '0;
      end else begin
        up_move   = '0;
        down_move = '0;
      end
    end
    last_high = hi;
    last_low  = lo;

    plus_total        = plus_total - plus_hist[slot] + up_move;
    minus_total       = minus_total - minus_hist[slot] + down_move;
    plus_hist[slot]   = up_move;
    minus_hist[slot]  = down_move;

    if (bars_seen >= WIN - 1) begin
      both   = plus_total + minus_total;
      spread = (plus_total > minus_total) ? plus_total - minus_total
                                          : minus_total - plus_total;
      if (both != '0) begin
        scaled = (64'(spread) * 64'(DX_SCALE)) << DEF_FRAC_BITS;
        dx_now = fixed_t'(scaled / 64'(both));
      end
    end
    dx_total      = dx_total - dx_hist[slot] + dx_now;
    dx_hist[slot] = dx_now;
    slot          = (slot + 1) % WIN;

    if (bars_seen >= VALID_AT) begin
      adx_total   = dx_total;
      beat.adx    = fixed_t'(dx_total / DXSUM_W'(WIN));
      beat.rising = (dx_total >= last_adx_total);
      beat.valid  = 1'b1;
    end
    beat.dx        = dx_now;
    last_adx_total = adx_total;
    if (bars_seen < VALID_AT) begin
      bars_seen++;
    end
    return beat;
  endfunction

  always @(posedge clk) begin
    index_beat_t got;
    index_beat_t want;
    if (!rst_n) begin
      last_high      = '0;
      last_low       = '0;
      plus_total     = '0;
      minus_total    = '0;
      dx_total       = '0;
      last_adx_total = '0;
      bars_seen      = 0;
      slot           = 0;
      for (int k = 0; k < WIN; k++) begin
        plus_hist[k]  = '0;
        minus_hist[k] = '0;
        dx_hist[k]    = '0;
      end
      index_due.delete();
      mismatches = 0;
      pending   <= 0;
    end else begin
      // compare first: a result beat always belongs to an earlier bar
      if (res.valid && res.ready) begin
        got = {res.adx_value, res.dx_value, res.trend_rising, res.adx_valid};
        if (index_due.size() == 0) begin
          report_mismatch("result beat with no bar pending, adx_value", got.adx, 0);
        end else begin
          want = index_due.pop_front();
          if (got.adx != want.adx) report_mismatch("adx_value", got.adx, want.adx);
          if (got.dx != want.dx) report_mismatch("dx_value", got.dx, want.dx);
          if (got.rising != want.rising) begin
            report_mismatch("trend_rising", got.rising, want.rising);
          end
          if (got.valid != want.valid) report_mismatch("adx_valid", got.valid, want.valid);
        end
      end
      if (bar.valid && bar.ready) begin
        index_due.push_back(index_after_bar(bar.bar_high, bar.bar_low));
      end
      pending <= index_due.size();
    end
  end

endmodule

// ===== bench/tb_directional_movement_index.sv =====
// Top of the directional movement index bench: clock, reset, bar stimulus and verdict.
`timescale 1ns / 1ps

module tb_directional_movement_index;
  import dmi_pkg::*;

  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     RANDOM_BARS  = 800;
  // drain time after the last predicted beat, to watch for stray result beats
  localparam int     DRAIN_CYCLES = 150;
  localparam longint PRICE_TOP    = (longint'(1) << IN_PRICE_W) - 1;

  typedef logic [IN_PRICE_W-1:0] price_t;

  // shapes of random bursts: trending walk, frozen bars, raw noise
  typedef enum int {BURST_TREND, BURST_FLAT, BURST_NOISE} burst_kind_t;
  // receiver moods: always ready, short frequent stalls, long rare stalls
  typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} rx_mood_t;

  localparam price_t PRICE_MAX = '1;
  localparam price_t PRICE_MIN = '0;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   mismatches;
  int   pending;

  dmi_bar_if bar_ch ();
  dmi_res_if res_ch ();

  directional_movement_index dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bar  (bar_ch),
    .out_res (res_ch)
  );

  dmi_result_checker checker_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .bar        (bar_ch),
    .res        (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_directional_movement_index: done, errors");
      $finish;
    end
  end

  // Clip a walked price back into the field's range.
  function automatic price_t price_clip(input longint p);
    if (p < 0) return PRICE_MIN;
    if (p > PRICE_TOP) return PRICE_MAX;
    return price_t'(p);
  endfunction

  // Present one bar at the falling edge and hold it until the block takes the beat.
  task automatic send_bar(input price_t hi, input price_t lo, input price_t cl);
    @(negedge clk);
    bar_ch.valid     <= 1'b1;
    bar_ch.bar_high  <= hi;
    bar_ch.bar_low   <= lo;
    bar_ch.bar_close <= cl;
    @(posedge clk);
    while (!bar_ch.ready) @(posedge clk);
  endtask

  // Drop valid for a hold-off of n; scramble idle payload so the block must ignore it.
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      bar_ch.valid     <= 1'b0;
      bar_ch.bar_high  <= price_t'($urandom);
      bar_ch.bar_low   <= price_t'($urandom);
      bar_ch.bar_close <= price_t'($urandom);
    end
  endtask

  // Edge cases first: the opening bar, a dead-flat window, ties, the largest moves.
  task automatic directed_bars();
    // opening bar: nothing to compare against, both moves come out zero
    send_bar(PRICE_MAX, PRICE_MIN, PRICE_MIN);
    // repeat it past a full window so DX goes live with P+M still zero
    repeat (10) send_bar(PRICE_MAX, PRICE_MIN, PRICE_MAX);
    // low above high, no move either way
    send_bar(PRICE_MIN, PRICE_MAX, PRICE_MIN);
    // full-scale move in both directions at once: the tie cancels both
    send_bar(PRICE_MAX, PRICE_MIN, PRICE_MAX);
    send_bar(PRICE_MIN, PRICE_MAX, PRICE_MIN);
    // largest minus move, then largest plus move
    send_bar(PRICE_MIN, PRICE_MIN, PRICE_MAX);
    send_bar(PRICE_MAX, PRICE_MIN, PRICE_MIN);
    // small moves around mid-scale; the third of these lands on the first valid ADX
    send_bar(24'h800001, 24'h7FFFFE, 24'h800000);
    send_bar(24'h800003, 24'h7FFFFD, 24'h7FFFFF);
    send_bar(24'h800004, 24'h7FFFF9, 24'h800002);
    send_bar(24'h800005, 24'h7FFFF8, 24'h800001);
    // alternating bit patterns, ending with two bars that carry them on every field
    send_bar(PRICE_MAX, 24'h000001, 24'h555555);
    send_bar(24'h555555, 24'hAAAAAA, 24'hAAAAAA);
    send_bar(24'hAAAAAA, 24'h555555, 24'h555555);
  endtask

  // Random bursts: mostly trending price walks so DX and ADX sweep their range,
  // some frozen runs long enough to zero the window, and some raw noise.
  task automatic random_bars(input int count);
    int          sent;
    int          burst;
    int          pick;
    int          step_max;
    int          half;
    longint      center;
    longint      drift;
    longint      jitter;
    burst_kind_t kind;
    price_t      hi;
    price_t      lo;
    sent   = 0;
    center = PRICE_TOP / 2;
    hi     = price_t'(center);
    lo     = price_t'(center);
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) kind = BURST_TREND;
      else if (pick < 9) kind = BURST_FLAT;
      else kind = BURST_NOISE;
      burst    = (kind == BURST_FLAT) ? $urandom_range(10, 14) : $urandom_range(1, 24);
      step_max = 1 << $urandom_range(0, 21);
      drift    = longint'($urandom_range(0, 2 * step_max)) - step_max;
      half     = $urandom_range(0, step_max);
      repeat (burst) begin
        case (kind)
          BURST_NOISE: begin
            hi = price_t'($urandom);
            lo = price_t'($urandom);
          end
          BURST_FLAT: begin
            // repeat the previous bar unchanged
          end
          default: begin
            jitter = longint'($urandom_range(0, 2 * step_max)) - step_max;
            center = center + drift + jitter;
            if (center < 0) center = 0;
            if (center > PRICE_TOP) center = PRICE_TOP;
            hi = price_clip(center + half + $urandom_range(0, step_max));
            lo = price_clip(center - half - $urandom_range(0, step_max));
          end
        endcase
        send_bar(hi, lo, price_t'($urandom));
        sent++;
      end
      // leave some bursts back to back so stretches run without idling
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 70));
    end
  endtask

  // Receiver: stall on a pattern whose mood is redrawn from time to time.
  initial begin
    int       stall_left;
    rx_mood_t mood;
    res_ch.ready <= 1'b0;
    stall_left = 0;
    mood       = RX_STEADY;
    forever begin
      @(negedge clk);
      if (cycle_count % 700 == 0) mood = rx_mood_t'($urandom_range(0, 2));
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        case (mood)
          RX_CHOPPY: begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 4);
          end
          RX_SLUGGISH: begin
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(10, 40);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sender: reset once, run directed then random bars, drain, give the verdict.
  initial begin
    rst_n            <= 1'b0;
    bar_ch.valid     <= 1'b0;
    bar_ch.bar_high  <= '0;
    bar_ch.bar_low   <= '0;
    bar_ch.bar_close <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    hold_off($urandom_range(1, 5));
    directed_bars();
    hold_off($urandom_range(1, 40));
    random_bars(RANDOM_BARS);

    @(negedge clk);
    bar_ch.valid <= 1'b0;
    // wait for every predicted beat, then watch for strays
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_directional_movement_index: done, clean");
    end else begin
      $display("tb_directional_movement_index: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dmi_pkg.sv
hdl/dmi_if.sv
hdl/directional_movement_index.sv
hdl/dmi_checker.sv
bench/dmi_result_checker.sv
bench/tb_directional_movement_index.sv
